>>> hw/rtl/nmea_pkg.sv
// shared types, codes and helpers for the nmea sentence checker and splitter
package nmea_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [1:0] ADDR_FULL   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SKIP = 3'd1,
        PH_BODY = 3'd2,
        PH_CK0  = 3'd3,
        PH_CK1  = 3'd4,
        PH_CK2  = 3'd5,
        PH_BAD  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_DOLLAR = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_NO_STAR   = 3'd3,
        ERR_CK_FORMAT = 3'd4,
        ERR_MISMATCH  = 3'd5,
        ERR_SHORT_ADR = 3'd6
    } err_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    // ascii hex digit, either case
    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h37);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/nmea_sentence_checker_splitter.sv
// NMEA sentence checker and field splitter, one character per request.
// Each accepted input character yields exactly one registered result: the
// parse state is updated and the result is formed in the same cycle, straight
// into an output register. A new character is taken every cycle as long as the
// output register is empty or being drained, so the sustained rate is one
// character per clock; the output register alone sets that figure. Body bytes
// between '$' and '*' come out as payload tagged with their field index before
// the verdict; the result for the final character (tlast) carries the verdict,
// error code and, for a good line, field count and last three address characters.
module nmea_sentence_checker_splitter
    import nmea_pkg::*;
#(
    parameter int LINE_LIMIT = 128,
    parameter int MAX_FIELDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_byte[7:0], field_index[12:8], line_ok[13], error_code[16:14],
    // field_count[22:17], sentence_type[46:23], zero pad [47]
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // payload_valid[0], separator[1]
    output logic        m_axis_tlast    // line_done
);

    localparam int         FIELD_LIMIT = (MAX_FIELDS > 32) ? 32 : MAX_FIELDS;
    localparam logic [5:0] FIELD_LIM6  = 6'(FIELD_LIMIT);
    localparam logic [7:0] LINE_LIM8   = 8'(LINE_LIMIT);

    phase_t      phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  len_reg, len_next;
    logic [4:0]  field_reg, field_next;
    logic [1:0]  addr_len_reg, addr_len_next;
    logic [23:0] type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    err_t        first_err_reg, first_err_next;

    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    logic [7:0]  c;
    logic [7:0]  len_inc;
    nibble_t     nib;
    logic        pay_valid;
    logic        sep;
    logic [4:0]  pay_field;
    phase_t      ph_after;
    logic [7:0]  xor_after;
    logic [7:0]  sum_after;
    logic [4:0]  field_after;
    logic [1:0]  addr_after;
    logic [23:0] type_after;
    err_t        ferr_after;
    err_t        verdict;
    logic        ok;
    logic [5:0]  count;
    logic [23:0] stype;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign len_inc       = (len_reg != 8'hFF) ? len_reg + 8'd1 : len_reg;
    assign nib           = hex_nibble(c);

    // parse step for one character
    always_comb
    begin
        ph_after    = phase_reg;
        xor_after   = xor_reg;
        sum_after   = sum_reg;
        field_after = field_reg;
        addr_after  = addr_len_reg;
        type_after  = type_reg;
        ferr_after  = first_err_reg;
        pay_valid   = 1'b0;
        sep         = 1'b0;
        pay_field   = 5'd0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (c == CHAR_DOLLAR) begin
                    ph_after = PH_BODY;
                end
                else begin
                    ph_after   = PH_SKIP;
                    ferr_after = ERR_NO_DOLLAR;
                end
            end
            PH_BODY:
            begin
                if (c == CHAR_STAR) begin
                    ph_after = PH_CK0;
                end
                else begin
                    xor_after = xor_reg ^ c;
                    pay_valid = 1'b1;
                    pay_field = field_reg;
                    if (c == CHAR_COMMA && ({1'b0, field_reg} + 6'd1) < FIELD_LIM6) begin
                        sep         = 1'b1;
                        field_after = field_reg + 5'd1;
                    end
                    else if (field_reg == 5'd0) begin
                        if (addr_len_reg != ADDR_FULL) begin
                            addr_after = addr_len_reg + 2'd1;
                        end
                        type_after = {type_reg[15:0], c};
                    end
                end
            end
            PH_CK0:
            begin
                if (nib.ok) begin
                    sum_after = {nib.value, 4'd0};
                    ph_after  = PH_CK1;
                end
                else begin
                    ph_after   = PH_BAD;
                    ferr_after = ERR_CK_FORMAT;
                end
            end
            PH_CK1:
            begin
                if (nib.ok) begin
                    sum_after = {sum_reg[7:4], nib.value};
                    ph_after  = PH_CK2;
                end
                else begin
                    ph_after   = PH_BAD;
                    ferr_after = ERR_CK_FORMAT;
                end
            end
            PH_CK2:
            begin
                ph_after   = PH_BAD;
                ferr_after = ERR_CK_FORMAT;
            end
            default:
            begin
            end
        endcase
    end

    // verdict, lowest failing code wins
    always_comb
    begin
        if (ferr_after == ERR_NO_DOLLAR) begin
            verdict = ERR_NO_DOLLAR;
        end
        else if (len_inc >= LINE_LIM8) begin
            verdict = ERR_TOO_LONG;
        end
        else if (ph_after == PH_BODY) begin
            verdict = ERR_NO_STAR;
        end
        else if (ph_after != PH_CK2) begin
            verdict = ERR_CK_FORMAT;
        end
        else if (xor_after != sum_after) begin
            verdict = ERR_MISMATCH;
        end
        else if (addr_after != ADDR_FULL) begin
            verdict = ERR_SHORT_ADR;
        end
        else begin
            verdict = ERR_NONE;
        end
        ok    = s_axis_tlast && (verdict == ERR_NONE);
        count = ok ? ({1'b0, field_after} + 6'd1) : 6'd0;
        stype = ok ? type_after : 24'd0;
    end

    // state update, cleared after the final character
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        len_next       = len_reg;
        field_next     = field_reg;
        addr_len_next  = addr_len_reg;
        type_next      = type_reg;
        sum_next       = sum_reg;
        first_err_next = first_err_reg;
        if (accept) begin
            if (s_axis_tlast) begin
                phase_next     = PH_IDLE;
                xor_next       = 8'd0;
                len_next       = 8'd0;
                field_next     = 5'd0;
                addr_len_next  = 2'd0;
                type_next      = 24'd0;
                sum_next       = 8'd0;
                first_err_next = ERR_NONE;
            end
            else begin
                phase_next     = ph_after;
                xor_next       = xor_after;
                len_next       = len_inc;
                field_next     = field_after;
                addr_len_next  = addr_after;
                type_next      = type_after;
                sum_next       = sum_after;
                first_err_next = ferr_after;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, stype, count,
                              s_axis_tlast ? verdict : ERR_NONE,
                              ok, pay_field, pay_valid ? c : 8'd0};
            out_user_next  = {sep, pay_valid};
            out_last_next  = s_axis_tlast;
        end
        else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            xor_reg       <= 8'd0;
            len_reg       <= 8'd0;
            field_reg     <= 5'd0;
            addr_len_reg  <= 2'd0;
            type_reg      <= 24'd0;
            sum_reg       <= 8'd0;
            first_err_reg <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            len_reg       <= len_next;
            field_reg     <= field_next;
            addr_len_reg  <= addr_len_next;
            type_reg      <= type_next;
            sum_reg       <= sum_next;
            first_err_reg <= first_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> tb/tb_nmea_sentence_checker_splitter.sv
// testbench for the nmea sentence checker and field splitter
module tb_nmea_sentence_checker_splitter;
    import nmea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT   = 128;
    localparam int MAX_FIELDS   = 32;
    localparam int FIELD_LIMIT  = (MAX_FIELDS > 32) ? 32 : MAX_FIELDS;
    localparam int RANDOM_CHARS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 64;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    nmea_sentence_checker_splitter #(
        .LINE_LIMIT (LINE_LIMIT),
        .MAX_FIELDS (MAX_FIELDS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic [4:0]  fld_idx;
        logic        sep;
        logic        done;
        logic        ok;
        err_t        err;
        logic [5:0]  nfields;
        logic [23:0] stype;
    } split_res_t;

    typedef struct {
        string text;
        err_t  code;
    } line_row_t;

    // parser state mirrored from the block
    phase_t      pr_phase;
    logic [7:0]  pr_xsum;
    int          pr_len;
    logic [4:0]  pr_field;
    logic [1:0]  pr_adr_len;
    logic [23:0] pr_type;
    logic [7:0]  pr_rx_sum;
    logic        pr_no_dollar;

    split_res_t  awaited_results[$];
    logic [7:0]  line_buf[$];
    line_row_t   dir_rows[6];

    int          send_gap_pct;
    int          stall_pct;
    int          accepted_chars;
    int          fail_count;
    int          cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // {valid, value} of an ascii hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return {1'b1, 4'(c - 8'h30)};
        if (c inside {[8'h41:8'h46]}) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        if (c inside {[8'h61:8'h66]}) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void clear_parse();
        pr_phase     = PH_IDLE;
        pr_xsum      = '0;
        pr_len       = 0;
        pr_field     = '0;
        pr_adr_len   = '0;
        pr_type      = '0;
        pr_rx_sum    = '0;
        pr_no_dollar = 1'b0;
    endfunction

    // one character through the parser, returns what the block should emit
    function automatic split_res_t parse_char(input logic [7:0] c, input logic last);
        split_res_t r;
        logic [4:0] hx;
        err_t       e;
        r.pay_valid = 1'b0;
        r.pay_byte  = '0;
        r.fld_idx   = '0;
        r.sep       = 1'b0;
        r.done      = 1'b0;
        r.ok        = 1'b0;
        r.err       = ERR_NONE;
        r.nfields   = '0;
        r.stype     = '0;
        hx = hex_digit(c);
        if (pr_len < 255) pr_len++;
        case (pr_phase)
            PH_IDLE: begin
                if (c == CHAR_DOLLAR) begin
                    pr_phase = PH_BODY;
                end
                else begin
                    pr_phase     = PH_SKIP;
                    pr_no_dollar = 1'b1;
                end
            end
            PH_BODY: begin
                if (c == CHAR_STAR) begin
                    pr_phase = PH_CK0;
                end
                else begin
                    pr_xsum     ^= c;
                    r.pay_valid = 1'b1;
                    r.pay_byte  = c;
                    r.fld_idx   = pr_field;
                    if (c == CHAR_COMMA && int'(pr_field) + 1 < FIELD_LIMIT) begin
                        r.sep    = 1'b1;
                        pr_field = pr_field + 5'd1;
                    end
                    else if (pr_field == 5'd0) begin
                        if (pr_adr_len < ADDR_FULL) pr_adr_len++;
                        pr_type = {pr_type[15:0], c};
                    end
                end
            end
            PH_CK0: begin
                if (hx[4]) begin
                    pr_rx_sum = {hx[3:0], 4'h0};
                    pr_phase  = PH_CK1;
                end
                else begin
                    pr_phase = PH_BAD;
                end
            end
            PH_CK1: begin
                if (hx[4]) begin
                    pr_rx_sum[3:0] = hx[3:0];
                    pr_phase       = PH_CK2;
                end
                else begin
                    pr_phase = PH_BAD;
                end
            end
            PH_CK2: pr_phase = PH_BAD;
            default: ;
        endcase
        if (last) begin
            if (pr_no_dollar)                e = ERR_NO_DOLLAR;
            else if (pr_len >= LINE_LIMIT)   e = ERR_TOO_LONG;
            else if (pr_phase == PH_BODY)    e = ERR_NO_STAR;
            else if (pr_phase != PH_CK2)     e = ERR_CK_FORMAT;
            else if (pr_xsum != pr_rx_sum)   e = ERR_MISMATCH;
            else if (pr_adr_len < ADDR_FULL) e = ERR_SHORT_ADR;
            else                             e = ERR_NONE;
            r.done = 1'b1;
            r.err  = e;
            if (e == ERR_NONE) begin
                r.ok      = 1'b1;
                r.nfields = {1'b0, pr_field} + 6'd1;
                r.stype   = pr_type;
            end
            clear_parse();
        end
        return r;
    endfunction

    function automatic string show(input split_res_t r);
        return $sformatf({"pv=%0b byte=%02h fld=%0d sep=%0b done=%0b ok=%0b",
                          " err=%0d cnt=%0d type=%06h"},
                         r.pay_valid, r.pay_byte, r.fld_idx, r.sep, r.done, r.ok, r.err,
                         r.nfields, r.stype);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last,
                             input bit typed, input err_t code);
        split_res_t r;
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = parse_char(c, last);
        if (last && typed) begin
            r.err = code;
            r.ok  = (code == ERR_NONE);
        end
        awaited_results.push_back(r);
        accepted_chars++;
    endtask

    task automatic send_line(input bit typed, input err_t code);
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1, typed, code);
    endtask

    function automatic logic [7:0] rand_non_star();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_STAR);
        return c;
    endfunction

    function automatic logic [7:0] rand_field_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) return CHAR_COMMA;
        if (pick < 75) begin
            logic [7:0] c;
            do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CHAR_STAR);
            return c;
        end
        return rand_non_star();
    endfunction

    function automatic logic [7:0] rand_addr_char();
        logic [7:0] c;
        if ($urandom_range(99) < 70) return 8'($urandom_range(8'h41, 8'h5A));
        do c = rand_non_star(); while (c == CHAR_COMMA);
        return c;
    endfunction

    // builds one sentence, well formed or broken, into line_buf
    function automatic void build_line();
        int         kind;
        int         adr_n;
        int         nfld;
        int         flen;
        int         target;
        int         star_at;
        logic [7:0] ck;
        logic [7:0] c;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind >= 94) begin
            // plain noise, now and then starting like a sentence
            for (int i = $urandom_range(1, 12); i > 0; i--)
                line_buf.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(4) == 0) line_buf[0] = CHAR_DOLLAR;
            return;
        end
        line_buf.push_back(CHAR_DOLLAR);
        adr_n = ($urandom_range(99) < 75) ? 5 : $urandom_range(0, 6);
        for (int i = 0; i < adr_n; i++) line_buf.push_back(rand_addr_char());
        nfld = (kind >= 78 && kind < 84) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        for (int f = 0; f < nfld; f++) begin
            line_buf.push_back(CHAR_COMMA);
            flen = (nfld > 20) ? $urandom_range(0, 2) : $urandom_range(0, 6);
            for (int i = 0; i < flen; i++) line_buf.push_back(rand_field_char());
        end
        if (kind >= 84 && kind < 88) begin
            // around the length limit, sometimes far past it
            target = ($urandom_range(3) == 0) ? $urandom_range(200, 300)
                                              : $urandom_range(LINE_LIMIT - 6, LINE_LIMIT + 6);
            while (line_buf.size() + 3 < target) line_buf.push_back(rand_field_char());
        end
        ck = '0;
        for (int i = 1; i < line_buf.size(); i++) ck ^= line_buf[i];
        if (kind >= 55 && kind < 62) ck ^= 8'($urandom_range(1, 255));
        star_at = line_buf.size();
        line_buf.push_back(CHAR_STAR);
        line_buf.push_back(hex_char(ck[7:4], 1'($urandom_range(1))));
        line_buf.push_back(hex_char(ck[3:0], 1'($urandom_range(1))));
        if (kind >= 62 && kind < 68) begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
                line_buf.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind >= 68 && kind < 73) begin
            // cut short somewhere before the checksum is complete
            line_buf = line_buf[0:$urandom_range(0, star_at + 1)];
        end
        else if (kind >= 73 && kind < 78) begin
            do c = 8'($urandom_range(1, 255)); while (c == CHAR_DOLLAR);
            line_buf[0] = c;
        end
        else if (kind >= 88) begin
            do c = 8'($urandom_range(1, 255)); while (hex_digit(c) != 5'd0);
            line_buf[star_at + $urandom_range(1, 2)] = c;
        end
    endfunction

    // result side: check each accepted result, then pick the next ready
    initial begin
        split_res_t got;
        split_res_t exp_r;
        bit         hold_done;
        int         hold_left;
        m_axis_tready <= 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) begin
                got.pay_valid = m_axis_tuser[0];
                got.sep       = m_axis_tuser[1];
                got.done      = m_axis_tlast;
                got.pay_byte  = m_axis_tdata[7:0];
                got.fld_idx   = m_axis_tdata[12:8];
                got.ok        = m_axis_tdata[13];
                got.err       = err_t'(m_axis_tdata[16:14]);
                got.nfields   = m_axis_tdata[22:17];
                got.stype     = m_axis_tdata[46:23];
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected request out: %s", show(got));
                end
                else begin
                    exp_r = awaited_results.pop_front();
                    if (got.pay_valid !== exp_r.pay_valid || got.pay_byte !== exp_r.pay_byte
                        || got.fld_idx !== exp_r.fld_idx || got.sep !== exp_r.sep
                        || got.done !== exp_r.done || got.ok !== exp_r.ok
                        || got.err !== exp_r.err || got.nfields !== exp_r.nfields
                        || got.stype !== exp_r.stype) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show(exp_r), show(got));
                    end
                end
            end
            // one long hold-off while the sender keeps pushing
            if (!hold_done && accepted_chars >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int rand_start;
        int drain;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        rst_n         <= 1'b0;
        send_gap_pct   = 0;
        stall_pct      = 0;
        accepted_chars = 0;
        fail_count     = 0;
        clear_parse();

        dir_rows[0] = '{"x", ERR_NO_DOLLAR};
        dir_rows[1] = '{"$", ERR_NO_STAR};
        dir_rows[2] = '{"$AB*03", ERR_SHORT_ADR};
        dir_rows[3] = '{"$*0", ERR_CK_FORMAT};
        dir_rows[4] = '{"$ABC,*6c", ERR_NONE};
        // mismatch outranks the short address
        dir_rows[5] = '{"$A*00", ERR_MISMATCH};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r]) begin
            line_buf.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                line_buf.push_back(dir_rows[r].text[i]);
            send_line(1'b1, dir_rows[r].code);
        end

        rand_start = accepted_chars;
        while (accepted_chars - rand_start < RANDOM_CHARS) begin
            case ((accepted_chars - rand_start) * 4 / RANDOM_CHARS)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 61; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 61; end
                default: begin send_gap_pct = 9;  stall_pct = 9;  end
            endcase
            build_line();
            send_line(1'b0, ERR_NONE);
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge clk);
        // keep clocking a while to catch anything extra
        for (drain = 0; drain < 8; drain++) @(posedge clk);

        if (fail_count == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
